[sv/rrfp_pkg.sv]
// Shared types and constants for the radar report frame parser.
`default_nettype none

package rrfp_pkg;

  localparam logic [7:0] HDR_B0 = 8'hF4;
  localparam logic [7:0] HDR_B1 = 8'hF3;
  localparam logic [7:0] HDR_B2 = 8'hF2;
  localparam logic [7:0] HDR_B3 = 8'hF1;
  localparam logic [7:0] TGT_STATE_MAX = 8'h03;

  localparam int unsigned POS_STATE   = 2;
  localparam int unsigned POS_MOV_LO  = 3;
  localparam int unsigned POS_MOV_HI  = 4;
  localparam int unsigned POS_MOV_EN  = 5;
  localparam int unsigned POS_STA_LO  = 6;
  localparam int unsigned POS_STA_HI  = 7;
  localparam int unsigned POS_STA_EN  = 8;
  localparam int unsigned POS_DET_LO  = 9;
  localparam int unsigned POS_DET_HI  = 10;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_H2      = 3'd1,
    PH_H3      = 3'd2,
    PH_H4      = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_LEN_HI  = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0]  target_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_energy;
    logic [15:0] static_distance;
    logic [7:0]  static_energy;
    logic [15:0] detect_distance;
  } report_t;

endpackage

`default_nettype wire

[sv/rrfp_in_reg.sv]
// Input register holding one received byte for the parser stage.
`default_nettype none

module rrfp_in_reg
  import rrfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       adv_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign in_stall_o = valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

[sv/rrfp_parser.sv]
// Frame state machine, payload capture and report decode.
`default_nettype none

module rrfp_parser
  import rrfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 13
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            emit_o,
  output report_t         report_o
);

  localparam int unsigned IdxW = $clog2(PAYLOAD_BYTES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PAYLOAD_BYTES - 1);

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [1:0]      last_st_q, last_st_d;
  logic [7:0]      pl_q [POS_STATE:POS_DET_HI];
  logic [7:0]      pl_v [POS_STATE:POS_DET_HI];
  logic            in_payload;

  assign in_payload = (phase_q == PH_PAYLOAD);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    len_lo_d = len_lo_q;
    unique case (phase_q)
      PH_HUNT:    phase_d = (byte_i == HDR_B0) ? PH_H2 : PH_HUNT;
      PH_H2:      phase_d = (byte_i == HDR_B1) ? PH_H3 : PH_HUNT;
      PH_H3:      phase_d = (byte_i == HDR_B2) ? PH_H4 : PH_HUNT;
      PH_H4:      phase_d = (byte_i == HDR_B3) ? PH_LEN_LO : PH_HUNT;
      PH_LEN_LO: begin
        len_lo_d = byte_i;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        idx_d = '0;
        if ({byte_i, len_lo_q} == 16'(PAYLOAD_BYTES)) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          phase_d = PH_HUNT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      default:    phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      idx_q     <= '0;
      len_lo_q  <= '0;
      last_st_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      len_lo_q  <= len_lo_d;
      last_st_q <= last_st_d;
    end
  end

  // Only the payload bytes that feed the report are kept.
  for (genvar k = POS_STATE; k <= POS_DET_HI; k++) begin : g_pl
    always_ff @(posedge clk_i) begin
      if (step_i && in_payload && idx_q == IdxW'(k)) begin
        pl_q[k] <= byte_i;
      end
    end
    assign pl_v[k] = (idx_q == IdxW'(k)) ? byte_i : pl_q[k];
  end

  // Outputs
  always_comb begin
    emit_o    = in_payload && (idx_q == IdxLast);
    last_st_d = last_st_q;
    if (emit_o && pl_v[POS_STATE] <= TGT_STATE_MAX) begin
      last_st_d = pl_v[POS_STATE][1:0];
    end
    report_o.target_state    = last_st_d;
    report_o.moving_distance = {pl_v[POS_MOV_HI], pl_v[POS_MOV_LO]};
    report_o.moving_energy   = pl_v[POS_MOV_EN];
    report_o.static_distance = {pl_v[POS_STA_HI], pl_v[POS_STA_LO]};
    report_o.static_energy   = pl_v[POS_STA_EN];
    report_o.detect_distance = {pl_v[POS_DET_HI], pl_v[POS_DET_LO]};
  end

endmodule

`default_nettype wire

[sv/rrfp_out_reg.sv]
// Result register for decoded reports.
`default_nettype none

module rrfp_out_reg
  import rrfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire report_t report_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output report_t      report_o
);

  logic    valid_q, valid_d;
  report_t rep_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rep_q <= report_i;
    end
  end

  assign out_valid_o = valid_q;
  assign report_o    = rep_q;

endmodule

`default_nettype wire

[sv/radar_report_frame_parser.sv]
// Top level of the radar report frame parser.
//
//   channel | signals                         | transaction
//   --------+---------------------------------+---------------------------------
//   in      | in_valid_i, in_stall_o          | rx_byte_i, one serial byte
//   out     | out_valid_o, out_stall_i        | one decoded target report
//
// A byte is taken every cycle while in_stall_o is low; it is parsed from the input
// register, and the report it completes is registered in the result register.
// The input register and the result register are the only pipeline stages.
// rst_ni clears the parser to hunting for a header and empties both stages.
// A stalled report blocks the input only when the next byte completes a frame.
`default_nettype none

module radar_report_frame_parser
  import rrfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 13
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       target_state_o,
  output logic [15:0]      moving_distance_o,
  output logic [7:0]       moving_energy_o,
  output logic [15:0]      static_distance_o,
  output logic [7:0]       static_energy_o,
  output logic [15:0]      detect_distance_o
);

  logic       st_valid;
  logic [7:0] st_byte;
  logic       emit;
  logic       out_free;
  logic       adv;
  report_t    rep_d;
  report_t    rep_q;

  assign adv = st_valid && (!emit || out_free);

  rrfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (adv),
    .valid_o    (st_valid),
    .byte_o     (st_byte)
  );

  rrfp_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .byte_i   (st_byte),
    .emit_o   (emit),
    .report_o (rep_d)
  );

  rrfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && emit),
    .report_i    (rep_d),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .report_o    (rep_q)
  );

  assign target_state_o    = rep_q.target_state;
  assign moving_distance_o = rep_q.moving_distance;
  assign moving_energy_o   = rep_q.moving_energy;
  assign static_distance_o = rep_q.static_distance;
  assign static_energy_o   = rep_q.static_energy;
  assign detect_distance_o = rep_q.detect_distance;

endmodule

`default_nettype wire

[tb/sv/radar_report_frame_parser_tb.sv]
// Self-checking testbench for the radar report frame parser: directed table, then random frames.
`default_nettype none

module radar_report_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrfp_pkg::*;

  localparam int unsigned PAYLOAD_BYTES = 13;
  localparam int RAND_BYTES_PER_PHASE = 368;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] HDR [4] = '{HDR_B0, HDR_B1, HDR_B2, HDR_B3};

  typedef struct packed {
    logic [7:0] rx;
    logic       fixed;
    report_t    rpt;
  } stim_row_t;

  localparam report_t NO_RPT = '0;
  localparam report_t ALL_ONES_RPT = '{
    target_state:    2'd0,
    moving_distance: 16'hFFFF,
    moving_energy:   8'hFF,
    static_distance: 16'hFFFF,
    static_energy:   8'hFF,
    detect_distance: 16'hFFFF
  };

  localparam int DIR_ROWS = 32;
  // second F4 breaks the header and is not taken as a new start; then a bad
  // length (0x010D); then a full frame of 0xFF with an invalid target state
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'hF4, 1'b0, NO_RPT}, '{8'hF4, 1'b0, NO_RPT}, '{8'hF3, 1'b0, NO_RPT},
    '{8'hF2, 1'b0, NO_RPT}, '{8'hF1, 1'b0, NO_RPT}, '{8'h0D, 1'b0, NO_RPT},
    '{8'h00, 1'b0, NO_RPT},
    '{8'hF4, 1'b0, NO_RPT}, '{8'hF3, 1'b0, NO_RPT}, '{8'hF2, 1'b0, NO_RPT},
    '{8'hF1, 1'b0, NO_RPT}, '{8'h0D, 1'b0, NO_RPT}, '{8'h01, 1'b0, NO_RPT},
    '{8'hF4, 1'b0, NO_RPT}, '{8'hF3, 1'b0, NO_RPT}, '{8'hF2, 1'b0, NO_RPT},
    '{8'hF1, 1'b0, NO_RPT}, '{8'h0D, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT},
    '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'hFF, 1'b1, ALL_ONES_RPT}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  target_state;
  logic [15:0] moving_distance;
  logic [7:0]  moving_energy;
  logic [15:0] static_distance;
  logic [7:0]  static_energy;
  logic [15:0] detect_distance;

  int snd_idle_pct = 34;
  int rcv_idle_pct = 50;
  int n_sent = 0;
  int err_cnt = 0;

  report_t pending_reports [$];

  // parser model state
  phase_e     prs_phase = PH_HUNT;
  int         prs_idx = 0;
  logic [7:0] prs_len_lo = 8'h00;
  logic [7:0] prs_store [PAYLOAD_BYTES];
  logic [1:0] prs_last_state = 2'd0;

  radar_report_frame_parser #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .target_state_o   (target_state),
    .moving_distance_o(moving_distance),
    .moving_energy_o  (moving_energy),
    .static_distance_o(static_distance),
    .static_energy_o  (static_energy),
    .detect_distance_o(detect_distance)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic frame_step(input logic [7:0] b, output bit got, output report_t rpt);
    got = 1'b0;
    rpt = '0;
    case (prs_phase)
      PH_HUNT:   prs_phase = (b == HDR_B0) ? PH_H2 : PH_HUNT;
      PH_H2:     prs_phase = (b == HDR_B1) ? PH_H3 : PH_HUNT;
      PH_H3:     prs_phase = (b == HDR_B2) ? PH_H4 : PH_HUNT;
      PH_H4:     prs_phase = (b == HDR_B3) ? PH_LEN_LO : PH_HUNT;
      PH_LEN_LO: begin
        prs_len_lo = b;
        prs_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if ({b, prs_len_lo} == 16'(PAYLOAD_BYTES)) begin
          prs_idx = 0;
          prs_phase = PH_PAYLOAD;
        end else begin
          prs_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        prs_store[prs_idx] = b;
        prs_idx++;
        if (prs_idx == PAYLOAD_BYTES) begin
          prs_idx = 0;
          prs_phase = PH_HUNT;
          if (prs_store[POS_STATE] <= TGT_STATE_MAX) prs_last_state = prs_store[POS_STATE][1:0];
          rpt.target_state    = prs_last_state;
          rpt.moving_distance = {prs_store[POS_MOV_HI], prs_store[POS_MOV_LO]};
          rpt.moving_energy   = prs_store[POS_MOV_EN];
          rpt.static_distance = {prs_store[POS_STA_HI], prs_store[POS_STA_LO]};
          rpt.static_energy   = prs_store[POS_STA_EN];
          rpt.detect_distance = {prs_store[POS_DET_HI], prs_store[POS_DET_LO]};
          got = 1'b1;
        end
      end
      default:   prs_phase = PH_HUNT;
    endcase
  endtask

  task automatic flag(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got, input logic [15:0] exp);
    if (got !== exp) flag($sformatf("%s got %0h, expected %0h", name, got, exp));
  endtask

  task automatic check_report();
    report_t exp;
    if (pending_reports.size() == 0) begin
      flag("report with no transaction pending");
    end else begin
      exp = pending_reports.pop_front();
      cmp_field("target_state", 16'(target_state), 16'(exp.target_state));
      cmp_field("moving_distance", moving_distance, exp.moving_distance);
      cmp_field("moving_energy", 16'(moving_energy), 16'(exp.moving_energy));
      cmp_field("static_distance", static_distance, exp.static_distance);
      cmp_field("static_energy", 16'(static_energy), 16'(exp.static_energy));
      cmp_field("detect_distance", detect_distance, exp.detect_distance);
    end
  endtask

  // receiver: stall decided at the edge, transaction judged at mid-cycle
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
      @(negedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_report();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fixed, input report_t fixed_rpt);
    bit acc;
    bit got;
    report_t rpt;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk);
      acc = (in_stall === 1'b0);
      @(posedge clk);
    end
    frame_step(b, got, rpt);
    if (fixed) pending_reports.push_back(fixed_rpt);
    else if (got) pending_reports.push_back(rpt);
    n_sent++;
  endtask

  function automatic logic [7:0] payload_val(input int pos);
    int roll;
    roll = $urandom_range(99);
    if (pos == POS_STATE) return (roll < 80) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    if (roll < 12) return 8'h00;
    if (roll < 24) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // mostly good frames; the rest noise, broken headers and wrong lengths
  task automatic send_frame();
    int roll;
    int cut;
    logic [7:0] b;
    logic [15:0] len;
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)), 1'b0, NO_RPT);
      return;
    end
    cut = (roll < 20) ? $urandom_range(3) : 4;
    for (int i = 0; i < 4; i++) begin
      if (i == cut) begin
        if (i != 0 && $urandom_range(1)) begin
          b = HDR_B0;
        end else begin
          do b = 8'($urandom_range(255)); while (b == HDR[i]);
        end
        send_byte(b, 1'b0, NO_RPT);
        return;
      end
      send_byte(HDR[i], 1'b0, NO_RPT);
    end
    len = 16'(PAYLOAD_BYTES);
    if (roll < 30) begin
      case ($urandom_range(2))
        0: len = $urandom_range(1) ? 16'(PAYLOAD_BYTES - 1) : 16'(PAYLOAD_BYTES + 1);
        1: len = {8'($urandom_range(1, 255)), 8'(PAYLOAD_BYTES)};
        default: len = 16'($urandom_range(65535));
      endcase
      if (len == 16'(PAYLOAD_BYTES)) len = len ^ 16'h8000;
    end
    send_byte(len[7:0], 1'b0, NO_RPT);
    send_byte(len[15:8], 1'b0, NO_RPT);
    if (len != 16'(PAYLOAD_BYTES)) return;
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(payload_val(i), 1'b0, NO_RPT);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) send_byte(DIR_TAB[i].rx, DIR_TAB[i].fixed, DIR_TAB[i].rpt);
    drain();
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          snd_idle_pct = 34;
          rcv_idle_pct = 50;
        end
        1: begin
          snd_idle_pct = 50;
          rcv_idle_pct = 34;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      target = n_sent + RAND_BYTES_PER_PHASE;
      while (n_sent < target) send_frame();
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("radar_report_frame_parser regression: pass");
    end else begin
      $display("radar_report_frame_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("ERROR: timeout");
    $display("radar_report_frame_parser regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/rrfp_pkg.sv
sv/rrfp_in_reg.sv
sv/rrfp_parser.sv
sv/rrfp_out_reg.sv
sv/radar_report_frame_parser.sv
tb/sv/radar_report_frame_parser_tb.sv
